// ----- src/tbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Tile bit-plane encoder package
// Shared widths, configuration register indexes, transfer types and the
// bit-plane gather function.
// ----------------------------------------------------------------------------
package tbe_pkg;

	localparam int ROWS      = 8;
	localparam int ROW_W     = 3;
	localparam int PIX_W     = 32;
	localparam int BYTE_W    = 8;
	localparam int STORE_W   = 2 * BYTE_W;
	localparam int PC_W      = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_ORDER = 1'b1;

	typedef struct packed {
		logic [PC_W-1:0] plane_count;
		logic            sprite_order;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] plane_byte;
		logic              last_of_item;
		logic              last_of_tile;
	} out_byte_t;

	// Pixel 0 of the row lands in the most significant bit of the byte.
	function automatic logic [BYTE_W-1:0] gather_plane(input logic [PIX_W-1:0] row,
			input logic [1:0] plane);
		logic [BYTE_W-1:0] b;
		b = '0;
		for (int dx = 0; dx < BYTE_W; dx++) begin
			b[BYTE_W-1-dx] = row[4*dx + int'(plane)];
		end
		return b;
	endfunction

endpackage

// ----- src/tbe_plane_ram.sv -----
// ----------------------------------------------------------------------------
// Upper plane store
// One write port and one read port; read data is registered and holds its
// value until the next read is issued.
// ----------------------------------------------------------------------------
module tbe_plane_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [tbe_pkg::ROW_W-1:0]   waddr,
	input  logic [tbe_pkg::STORE_W-1:0] wdata,
	input  logic                      re,
	input  logic [tbe_pkg::ROW_W-1:0]   raddr,
	output logic [tbe_pkg::STORE_W-1:0] rdata
);
	import tbe_pkg::*;

	logic [STORE_W-1:0] mem [ROWS];
	logic [STORE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/tbe_seq.sv -----
// ----------------------------------------------------------------------------
// Tile bit-plane encoder sequencer
// Takes one row, writes its upper plane pair into the store, with two or more
// planes emits the lower pair, and after a four-plane row 7 replays the store.
// ----------------------------------------------------------------------------
module tbe_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tbe_pkg::cfg_t           cfg,
	input  logic                    row_valid,
	output logic                    row_ready,
	input  logic [tbe_pkg::PIX_W-1:0] row_pixels,
	output logic                    byte_valid,
	input  logic                    byte_ready,
	output tbe_pkg::out_byte_t      byte_out
);
	import tbe_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_EMIT0   = 3'd1;
	localparam logic [2:0] ST_EMIT1   = 3'd2;
	localparam logic [2:0] ST_TAIL_HI = 3'd3;
	localparam logic [2:0] ST_TAIL_LO = 3'd4;

	logic [2:0]        state_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  k_q;
	logic              tail_q;
	logic              last_row_q;
	logic [BYTE_W-1:0] b0_q;
	logic [BYTE_W-1:0] b1_q;

	logic               accept;
	logic               has_pair;
	logic               four_planes;
	logic               last_row;
	logic [1:0]         p0, p1, p2, p3;
	logic               byte_take;
	logic               ram_re;
	logic [ROW_W-1:0]   ram_raddr;
	logic [STORE_W-1:0] ram_rdata;
	logic [STORE_W-1:0] upper_word;

	assign row_ready   = (state_q == ST_IDLE);
	assign accept      = row_valid && row_ready;
	assign has_pair    = cfg.plane_count[2] | cfg.plane_count[1];
	assign four_planes = cfg.plane_count[2];
	assign last_row    = (row_q == ROW_W'(ROWS - 1));
	assign byte_take   = byte_valid && byte_ready;

	always_comb begin
		if (cfg.sprite_order) begin
			p0 = 2'd0; p1 = 2'd1; p2 = 2'd3; p3 = 2'd2;
		end else begin
			p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; p3 = 2'd3;
		end
	end

	assign upper_word = {gather_plane(row_pixels, p2), gather_plane(row_pixels, p3)};

	// Store reads start only after the row-7 write has landed, so no
	// forwarding path is needed.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (state_q == ST_EMIT1 && byte_take && tail_q) begin
			ram_re = 1'b1;
		end else if (state_q == ST_TAIL_LO && byte_take && k_q != ROW_W'(ROWS - 1)) begin
			ram_re    = 1'b1;
			ram_raddr = k_q + ROW_W'(1);
		end
	end

	tbe_plane_ram u_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (row_q),
		.wdata (upper_word),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		byte_valid = 1'b0;
		byte_out   = '0;
		case (state_q)
			ST_EMIT0: begin
				byte_valid          = 1'b1;
				byte_out.plane_byte = b0_q;
			end
			ST_EMIT1: begin
				byte_valid            = 1'b1;
				byte_out.plane_byte   = b1_q;
				byte_out.last_of_item = !tail_q;
				byte_out.last_of_tile = last_row_q && !tail_q;
			end
			ST_TAIL_HI: begin
				byte_valid          = 1'b1;
				byte_out.plane_byte = ram_rdata[STORE_W-1:BYTE_W];
			end
			ST_TAIL_LO: begin
				byte_valid            = 1'b1;
				byte_out.plane_byte   = ram_rdata[BYTE_W-1:0];
				byte_out.last_of_item = (k_q == ROW_W'(ROWS - 1));
				byte_out.last_of_tile = (k_q == ROW_W'(ROWS - 1));
			end
			default: begin
				byte_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			row_q      <= '0;
			k_q        <= '0;
			tail_q     <= 1'b0;
			last_row_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_q      <= row_q + ROW_W'(1);
						tail_q     <= last_row && four_planes;
						last_row_q <= last_row;
						if (has_pair) begin
							state_q <= ST_EMIT0;
						end
					end
				end
				ST_EMIT0: begin
					if (byte_take) begin
						state_q <= ST_EMIT1;
					end
				end
				ST_EMIT1: begin
					if (byte_take) begin
						k_q     <= '0;
						state_q <= tail_q ? ST_TAIL_HI : ST_IDLE;
					end
				end
				ST_TAIL_HI: begin
					if (byte_take) begin
						state_q <= ST_TAIL_LO;
					end
				end
				ST_TAIL_LO: begin
					if (byte_take) begin
						if (k_q == ROW_W'(ROWS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + ROW_W'(1);
							state_q <= ST_TAIL_HI;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b0_q <= gather_plane(row_pixels, p0);
			b1_q <= gather_plane(row_pixels, p1);
		end
	end

	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> row_q == $past(row_q) + ROW_W'(1))
		else $error("row index did not advance on an accepted row");

	a_tail_only_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL_HI || state_q == ST_TAIL_LO) |-> (tail_q && last_row_q))
		else $error("store replay outside the last row of a four-plane tile");

	a_no_pair_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !has_pair) |=> state_q == ST_IDLE)
		else $error("row with fewer than two planes produced output");

	a_stalled_byte_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && !byte_ready) |=> $stable(byte_out))
		else $error("stalled byte changed, store read data not held");

endmodule

// ----- src/tile_bitplane_encoder_core.sv -----
// ----------------------------------------------------------------------------
// Tile bit-plane encoder core
// Converts 8x8 tiles of 4-bit pixels, one row per transaction, into planar
// bit-plane bytes; in four-plane mode the upper plane pair follows row 7.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[31:0] = row_pixels
//   m_axis    out        tdata[7:0] = plane_byte, tlast = last_of_item,
//                        tuser = last_of_tile
//   cfg       in         index 0 plane_count, index 1 sprite_order
//
// A row is taken while the sequencer is idle and its two bytes then leave the
// sequencer in turn; no new row is taken until both have gone. Each byte
// reaches the output port in the cycle after it leaves the sequencer. Row 7
// with four planes adds 16 store replay bytes, one per cycle while the output
// does not stall, read from the upper plane store, which has one write port
// and one read port.
// Reset returns the row counter to row 0 and the registers to two planes,
// normal order. Output stalls hold the sequencer; one output register
// decouples the sequencer from the output handshake.
// ----------------------------------------------------------------------------
module tile_bitplane_encoder_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tbe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tbe_pkg::CFG_W-1:0]     cfg_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [tbe_pkg::PIX_W-1:0]     s_axis_tdata,  // row_pixels
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [tbe_pkg::BYTE_W-1:0]    m_axis_tdata,  // plane_byte
	output logic                        m_axis_tlast,
	output logic                        m_axis_tuser   // last_of_tile
);
	import tbe_pkg::*;

	cfg_t      cfg_q;
	logic      byte_valid;
	logic      byte_ready;
	out_byte_t byte_out;
	logic      out_valid_q;
	out_byte_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane_count  <= PC_W'(2);
			cfg_q.sprite_order <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PLANE_COUNT:  cfg_q.plane_count  <= cfg_data[PC_W-1:0];
				REG_SPRITE_ORDER: cfg_q.sprite_order <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tbe_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.row_valid  (s_axis_tvalid),
		.row_ready  (s_axis_tready),
		.row_pixels (s_axis_tdata),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_out   (byte_out)
	);

	assign byte_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (byte_ready) begin
			out_valid_q <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			out_q <= byte_out;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.plane_byte;
	assign m_axis_tlast  = out_q.last_of_item;
	assign m_axis_tuser  = out_q.last_of_tile;

endmodule
